// ===== rtl/mamu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mamu_pkg - shared types and constants of the 6502 address mode unit
// Mode, phase and command codes, input and result word layouts, and the
// store opcodes that never take the page-cross penalty.
// ----------------------------------------------------------------------------
package mamu_pkg;

	// Addressing modes as carried in the start word
	typedef enum logic [3:0] {
		MODE_IMP = 4'd0,
		MODE_IMM = 4'd1,
		MODE_ZP0 = 4'd2,
		MODE_ZPX = 4'd3,
		MODE_ZPY = 4'd4,
		MODE_REL = 4'd5,
		MODE_ABS = 4'd6,
		MODE_ABX = 4'd7,
		MODE_ABY = 4'd8,
		MODE_IND = 4'd9,
		MODE_IZX = 4'd10,
		MODE_IZY = 4'd11
	} mode_t;

	// Sequencer phase
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_OP1   = 3'd1,
		PH_OP2   = 3'd2,
		PH_PLO   = 3'd3,
		PH_PHI   = 3'd4,
		PH_DUMMY = 3'd5
	} phase_t;

	// Input word command
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// Result word kind
	localparam logic KIND_REQ  = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// Indexed stores: no extra cycle on a page crossing
	localparam logic [7:0] OPC_SHY_ABX = 8'h9C;
	localparam logic [7:0] OPC_STA_ABX = 8'h9D;
	localparam logic [7:0] OPC_SHX_ABY = 8'h9E;
	localparam logic [7:0] OPC_STA_ABY = 8'h99;

	typedef struct packed {
		logic        command;
		logic [3:0]  mode;
		logic [15:0] pc;
		logic [7:0]  index_x;
		logic [7:0]  index_y;
		logic [7:0]  accumulator;
		logic [7:0]  opcode;
		logic [7:0]  read_data;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] bus_address;
		logic        is_dummy;
		logic [15:0] effective_address;
		logic [15:0] base_address;
		logic [15:0] relative_offset;
		logic [7:0]  fetched;
		logic        fetched_valid;
		logic [15:0] next_pc;
		logic        extra_cycle;
	} out_word_t;

endpackage
`default_nettype wire

// ===== rtl/mos6502_address_mode_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mos6502_address_mode_unit - 6502 addressing mode sequencer
// Steps through the twelve 6502 addressing modes one bus byte at a time and
// reports either the next read request or the finished address set.
// ----------------------------------------------------------------------------
// Every word that is not dropped gives one result word (input register, then
// result register), and a new word may be taken every cycle unless the
// output stalls: the only loop is the sequencer state, which is updated as a
// word leaves the input register. A start word drives the mode; each data
// word answers the last read request. IMP, IMM and unknown modes finish on
// the start word; the others issue one to four reads, including the optional
// dummy read of ABX, ABY and IZY (enabled by cfg_data, reset 1). A start
// while busy and data while idle are dropped without a result.
module mos6502_address_mode_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write,
	input  wire logic                cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire mamu_pkg::in_word_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output mamu_pkg::out_word_t      out_data
);
	import mamu_pkg::*;

	// Input stage
	logic      in_valid_s1;
	in_word_t  in_word_s1;
	// Result stage
	logic      res_valid_s2;
	out_word_t res_word_s2;

	// Sequencer state
	logic        dummy_en_q;
	phase_t      phase_q, nxt_phase;
	mode_t       mode_q, nxt_mode;
	logic [15:0] pc_q, nxt_pc;
	logic [7:0]  x_q, nxt_x;
	logic [7:0]  y_q, nxt_y;
	logic [7:0]  opc_q, nxt_opc;
	logic [7:0]  low_q, nxt_low;
	logic [7:0]  high_q, nxt_high;
	logic [15:0] addr_q, nxt_addr;
	logic [15:0] base_q, nxt_base;
	logic [15:0] off_q, nxt_off;

	// Step outputs
	logic        emit;
	logic        do_done;
	logic        fin_idx;
	logic        chk_extra;
	logic [7:0]  idx;
	logic [15:0] req_addr;
	logic        req_dummy;
	logic [7:0]  fetch_val;
	logic        fetch_vld;
	logic        crossed;
	logic        extra;
	logic        advance;
	out_word_t   res;
	logic [7:0]  b;

	assign b = in_word_s1.read_data;

	// Handshake: the input stage moves when its result has somewhere to go
	assign advance   = in_valid_s1 && (!emit || !res_valid_s2 || !out_stall);
	assign in_stall  = in_valid_s1 && !advance;
	assign out_valid = res_valid_s2;
	assign out_data  = res_word_s2;

	// Next state and result for the word in the input stage
	always_comb begin
		nxt_phase = phase_q;
		nxt_mode  = mode_q;
		nxt_pc    = pc_q;
		nxt_x     = x_q;
		nxt_y     = y_q;
		nxt_opc   = opc_q;
		nxt_low   = low_q;
		nxt_high  = high_q;
		nxt_addr  = addr_q;
		nxt_base  = base_q;
		nxt_off   = off_q;
		emit      = 1'b0;
		do_done   = 1'b0;
		fin_idx   = 1'b0;
		chk_extra = 1'b0;
		idx       = y_q;
		req_addr  = '0;
		req_dummy = 1'b0;
		fetch_val = '0;
		fetch_vld = 1'b0;

		if (in_word_s1.command == CMD_START) begin
			if (phase_q == PH_IDLE) begin
				emit     = 1'b1;
				nxt_mode = mode_t'(in_word_s1.mode);
				nxt_pc   = in_word_s1.pc;
				nxt_x    = in_word_s1.index_x;
				nxt_y    = in_word_s1.index_y;
				nxt_opc  = in_word_s1.opcode;
				unique case (in_word_s1.mode)
					MODE_IMP: begin
						do_done   = 1'b1;
						fetch_val = in_word_s1.accumulator;
						fetch_vld = 1'b1;
					end
					MODE_IMM: begin
						nxt_addr = in_word_s1.pc;
						nxt_pc   = in_word_s1.pc + 16'd1;
						do_done  = 1'b1;
					end
					MODE_ZP0, MODE_ZPX, MODE_ZPY, MODE_REL, MODE_ABS, MODE_ABX,
					MODE_ABY, MODE_IND, MODE_IZX, MODE_IZY: begin
						req_addr  = in_word_s1.pc;
						nxt_pc    = in_word_s1.pc + 16'd1;
						nxt_phase = PH_OP1;
					end
					default: do_done = 1'b1;
				endcase
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: ;
				PH_OP1: begin
					emit = 1'b1;
					unique case (mode_q)
						MODE_ZP0: begin
							nxt_addr = {8'h00, b};
							do_done  = 1'b1;
						end
						MODE_ZPX: begin
							nxt_addr = {8'h00, 8'(b + x_q)};
							do_done  = 1'b1;
						end
						MODE_ZPY: begin
							nxt_addr = {8'h00, 8'(b + y_q)};
							do_done  = 1'b1;
						end
						MODE_REL: begin
							nxt_off = {{8{b[7]}}, b};
							do_done = 1'b1;
						end
						MODE_IZX: begin
							nxt_low   = b;
							nxt_phase = PH_PLO;
							req_addr  = {8'h00, 8'(b + x_q)};
						end
						MODE_IZY: begin
							nxt_low   = b;
							nxt_phase = PH_PLO;
							req_addr  = {8'h00, b};
						end
						default: begin
							nxt_low   = b;
							req_addr  = pc_q;
							nxt_pc    = pc_q + 16'd1;
							nxt_phase = PH_OP2;
						end
					endcase
				end
				PH_OP2: begin
					emit     = 1'b1;
					nxt_high = b;
					nxt_base = {b, low_q};
					nxt_addr = {b, low_q};
					if (mode_q == MODE_ABX) begin
						nxt_addr = {b, low_q} + {8'h00, x_q};
						fin_idx  = 1'b1;
						idx      = x_q;
					end else if (mode_q == MODE_ABY) begin
						nxt_addr = {b, low_q} + {8'h00, y_q};
						fin_idx  = 1'b1;
					end else if (mode_q == MODE_IND) begin
						nxt_phase = PH_PLO;
						req_addr  = {b, low_q};
					end else begin
						do_done = 1'b1;
					end
				end
				PH_PLO: begin
					emit = 1'b1;
					// JMP indirect keeps the pointer high byte fetch in its page
					if (mode_q == MODE_IND)
						req_addr = (addr_q[7:0] == 8'hFF) ? {addr_q[15:8], 8'h00}
							: addr_q + 16'd1;
					else if (mode_q == MODE_IZX)
						req_addr = {8'h00, 8'(low_q + x_q + 8'd1)};
					else
						req_addr = {8'h00, 8'(low_q + 8'd1)};
					nxt_low   = b;
					nxt_phase = PH_PHI;
				end
				PH_PHI: begin
					emit     = 1'b1;
					nxt_high = b;
					if (mode_q == MODE_IZY) begin
						nxt_base = {b, low_q};
						nxt_addr = {b, low_q} + {8'h00, y_q};
						fin_idx  = 1'b1;
					end else begin
						nxt_addr = {b, low_q};
						do_done  = 1'b1;
					end
				end
				PH_DUMMY: begin
					emit      = 1'b1;
					do_done   = 1'b1;
					chk_extra = 1'b1;
				end
				default: nxt_phase = PH_IDLE;
			endcase
		end

		// End of an indexed mode: dummy read at the low-byte-only sum, or finish
		if (fin_idx) begin
			if (dummy_en_q) begin
				nxt_phase = PH_DUMMY;
				req_addr  = {nxt_base[15:8], 8'(nxt_base[7:0] + idx)};
				req_dummy = 1'b1;
			end else begin
				do_done   = 1'b1;
				chk_extra = 1'b1;
			end
		end
		if (do_done)
			nxt_phase = PH_IDLE;
	end

	// Page-cross penalty, with the indexed stores exempt
	always_comb begin
		crossed = nxt_addr[15:8] != nxt_base[15:8];
		extra   = 1'b0;
		if (chk_extra) begin
			if (nxt_mode == MODE_ABX)
				extra = crossed && nxt_opc != OPC_SHY_ABX && nxt_opc != OPC_STA_ABX;
			else if (nxt_mode == MODE_ABY)
				extra = crossed && nxt_opc != OPC_SHX_ABY && nxt_opc != OPC_STA_ABY;
			else if (nxt_mode == MODE_IZY)
				extra = crossed;
		end
	end

	// Result word assembly
	always_comb begin
		res = '0;
		if (do_done) begin
			res.kind              = KIND_DONE;
			res.effective_address = nxt_addr;
			res.base_address      = nxt_base;
			res.relative_offset   = nxt_off;
			res.fetched           = fetch_val;
			res.fetched_valid     = fetch_vld;
			res.next_pc           = nxt_pc;
			res.extra_cycle       = extra;
		end else begin
			res.kind        = KIND_REQ;
			res.bus_address = req_addr;
			res.is_dummy    = req_dummy;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			in_word_s1 <= in_data;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			res_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			res_word_s2 <= res;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dummy_en_q <= 1'b1;
		end else if (cfg_write) begin
			dummy_en_q <= cfg_data;
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mode_q  <= MODE_IMP;
			pc_q    <= '0;
			x_q     <= '0;
			y_q     <= '0;
			opc_q   <= '0;
			low_q   <= '0;
			high_q  <= '0;
			addr_q  <= '0;
			base_q  <= '0;
			off_q   <= '0;
		end else if (advance) begin
			phase_q <= nxt_phase;
			mode_q  <= nxt_mode;
			pc_q    <= nxt_pc;
			x_q     <= nxt_x;
			y_q     <= nxt_y;
			opc_q   <= nxt_opc;
			low_q   <= nxt_low;
			high_q  <= nxt_high;
			addr_q  <= nxt_addr;
			base_q  <= nxt_base;
			off_q   <= nxt_off;
		end
	end

	// Checks
	a_done_no_bus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_DONE |-> out_data.bus_address == 16'h0000
			&& !out_data.is_dummy)
		else $error("done word carries a bus request");

	a_fetch_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.fetched_valid |-> out_data.kind == KIND_DONE)
		else $error("implied operand on a request word");

	a_dummy_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DUMMY |-> dummy_en_q)
		else $error("dummy phase with dummy reads disabled");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> in_valid_s1 && res_valid_s2 && out_stall)
		else $error("input stalled with room downstream");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && do_done |=> phase_q == PH_IDLE)
		else $error("sequencer busy after a done word");

endmodule
`default_nettype wire
